// ----- src/qfrm_pkg.sv -----
// Shared constants, types and saturation helpers for the rotation matrix to quaternion core.
package qfrm_pkg;

   // Fixed-point format and field widths
   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 18;
   localparam int OUT_W     = 18;
   localparam int LANES     = 3;

   // Root argument: signed, wide enough for three elements plus one
   localparam int ARG_W  = (FRAC_BITS + 3 > 21) ? FRAC_BITS + 3 : 21;
   // Radicand, padded to an even number of bits
   localparam int V_W    = ARG_W - 1 + FRAC_BITS - 2;
   localparam int ROOT_W = (V_W + 1) / 2;
   localparam int SQ_W   = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 3;

   // Off-diagonal sums and differences: magnitude of a 19-bit signed value
   localparam int SUM_W  = IN_W + 1;
   localparam int MAG_W  = SUM_W;

   // Division: divisor is four times the half root
   localparam int DEN_W  = ROOT_W + 2;
   localparam int NUMA_W = (MAG_W + FRAC_BITS > DEN_W) ? MAG_W + FRAC_BITS : DEN_W;
   localparam int NUM_W  = NUMA_W + 1;
   // Quotient bits kept; anything larger saturates
   localparam int QB     = OUT_W;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // Slot that takes the half root: w, or the picked axis x, y or z
   typedef enum logic [1:0] {
      SLOT_W = 2'd0,
      SLOT_X = 2'd1,
      SLOT_Y = 2'd2,
      SLOT_Z = 2'd3
   } slot_type;

   typedef struct packed {
      slot_type   sel;
      logic       bad;
      logic [LANES-1:0] neg;
   } ctl_type;

   typedef struct packed {
      ctl_type                     ctl;
      logic [LANES-1:0][MAG_W-1:0] mag;
      logic [SQ_W-1:0]             v;
   } front_type;

   typedef struct packed {
      ctl_type                     ctl;
      logic [LANES-1:0][MAG_W-1:0] mag;
      logic [ROOT_W-1:0]           half;
   } root_type;

   typedef struct packed {
      ctl_type                  ctl;
      logic [ROOT_W-1:0]        half;
      logic [LANES-1:0]         ovf;
      logic [LANES-1:0][QB-1:0] q;
   } quot_type;

   // Saturate the half root to the output range
   function automatic logic signed [OUT_W-1:0] sat_half(input logic [ROOT_W-1:0] h);
      logic [ROOT_W:0] hx;
      hx = {1'b0, h};
      if (hx > (ROOT_W + 1)'(OUT_MAX)) begin
         return OUT_MAX;
      end
      return OUT_W'(h);
   endfunction

   // Apply sign and saturate one quotient lane
   function automatic logic signed [OUT_W-1:0] sat_lane(input logic neg, input logic ovf,
                                                        input logic [QB-1:0] q);
      logic [QB:0] qx;
      logic [QB:0] lim;
      qx = {1'b0, q};
      if (ovf) begin
         return neg ? OUT_MIN : OUT_MAX;
      end
      if (!neg) begin
         lim = (QB + 1)'(OUT_MAX);
         return (qx > lim) ? OUT_MAX : OUT_W'(q);
      end
      lim = (QB + 1)'(OUT_MAX) + (QB + 1)'(1);
      return (qx > lim) ? OUT_MIN : OUT_W'(-qx);
   endfunction

endpackage

// ----- src/qfrm_front.sv -----
// Front stage: branch and axis pick, root argument and off-diagonal sums.
module qfrm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic signed [qfrm_pkg::IN_W-1:0] r00,
   input  logic signed [qfrm_pkg::IN_W-1:0] r01,
   input  logic signed [qfrm_pkg::IN_W-1:0] r02,
   input  logic signed [qfrm_pkg::IN_W-1:0] r10,
   input  logic signed [qfrm_pkg::IN_W-1:0] r11,
   input  logic signed [qfrm_pkg::IN_W-1:0] r12,
   input  logic signed [qfrm_pkg::IN_W-1:0] r20,
   input  logic signed [qfrm_pkg::IN_W-1:0] r21,
   input  logic signed [qfrm_pkg::IN_W-1:0] r22,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output qfrm_pkg::front_type           dn_data
);
   import qfrm_pkg::*;

   localparam logic signed [ARG_W-1:0] ONE = ARG_W'(64'(1) << FRAC_BITS);

   logic signed [ARG_W-1:0] e00, e11, e22, trace, arg;
   logic signed [ARG_W-1:0] arg0, arg1, arg2, d_pick;
   logic                    pos, pick1, pick2;
   logic signed [SUM_W-1:0] s [LANES];
   logic [LANES-1:0]        neg;
   logic [LANES-1:0][MAG_W-1:0] mag;
   front_type               data_in;
   front_type               data_ff;
   logic                    vld_ff;

   // Diagonal terms and branch selection
   always_comb begin
      e00   = ARG_W'(r00);
      e11   = ARG_W'(r11);
      e22   = ARG_W'(r22);
      trace = e00 + e11 + e22;
      pos   = trace > 0;
      pick1 = e11 > e00;
      d_pick = pick1 ? e11 : e00;
      pick2 = e22 > d_pick;
      arg0  = e00 - e11 - e22 + ONE;
      arg1  = e11 - e22 - e00 + ONE;
      arg2  = e22 - e00 - e11 + ONE;
   end

   // Root argument and the three sums for the chosen case
   always_comb begin
      data_in = '0;
      if (pos) begin
         arg = trace + ONE;
         s[0] = SUM_W'(r21) - SUM_W'(r12);
         s[1] = SUM_W'(r02) - SUM_W'(r20);
         s[2] = SUM_W'(r10) - SUM_W'(r01);
         data_in.ctl.sel = SLOT_W;
      end else if (pick2) begin
         arg = arg2;
         s[0] = SUM_W'(r10) - SUM_W'(r01);
         s[1] = SUM_W'(r02) + SUM_W'(r20);
         s[2] = SUM_W'(r12) + SUM_W'(r21);
         data_in.ctl.sel = SLOT_Z;
      end else if (pick1) begin
         arg = arg1;
         s[0] = SUM_W'(r02) - SUM_W'(r20);
         s[1] = SUM_W'(r21) + SUM_W'(r12);
         s[2] = SUM_W'(r01) + SUM_W'(r10);
         data_in.ctl.sel = SLOT_Y;
      end else begin
         arg = arg0;
         s[0] = SUM_W'(r21) - SUM_W'(r12);
         s[1] = SUM_W'(r10) + SUM_W'(r01);
         s[2] = SUM_W'(r20) + SUM_W'(r02);
         data_in.ctl.sel = SLOT_X;
      end
      for (int n = 0; n < LANES; n++) begin
         neg[n] = s[n] < 0;
         mag[n] = neg[n] ? MAG_W'(-s[n]) : MAG_W'(s[n]);
      end
      data_in.ctl.bad = !pos && (arg <= 0);
      data_in.ctl.neg = neg;
      data_in.mag     = mag;
      data_in.v       = SQ_W'(arg[ARG_W-2:0]) << (FRAC_BITS - 2);
   end

   assign up_ready = !vld_ff || dn_ready;
   assign dn_valid = vld_ff;
   assign dn_data  = data_ff;

   // Advance when the stage is empty or its item moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- src/qfrm_sqrt.sv -----
// Square root pipeline: one root bit per stage, digit by digit.
module qfrm_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  qfrm_pkg::front_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output qfrm_pkg::root_type  dn_data
);
   import qfrm_pkg::*;

   typedef struct packed {
      ctl_type                     ctl;
      logic [LANES-1:0][MAG_W-1:0] mag;
      logic [SQ_W-1:0]             v;
      logic [REM_W-1:0]            rem;
      logic [ROOT_W-1:0]           root;
   } sq_stage_type;

   logic [ROOT_W-1:0] vld_ff;
   logic [ROOT_W:0]   rdy;
   sq_stage_type      st_ff [ROOT_W];
   sq_stage_type      st_in [ROOT_W];
   sq_stage_type      head;

   // Seed the first stage from the front item
   always_comb begin
      head.ctl  = up_data.ctl;
      head.mag  = up_data.mag;
      head.v    = up_data.v;
      head.rem  = '0;
      head.root = '0;
   end

   assign rdy[ROOT_W] = dn_ready;
   assign up_ready    = rdy[0];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      sq_stage_type     src;
      logic [REM_W-1:0] rem2, trial;
      logic             ge;
      logic             src_vld;

      if (s == 0) begin : g_first
         assign src     = head;
         assign src_vld = up_valid;
      end else begin : g_next
         assign src     = st_ff[s-1];
         assign src_vld = vld_ff[s-1];
      end

      assign rdy[s] = !vld_ff[s] || rdy[s+1];

      // Bring down two radicand bits and try the next root bit
      always_comb begin
         rem2  = {src.rem[REM_W-3:0], src.v[SQ_W-1 -: 2]};
         trial = REM_W'({src.root, 2'b01});
         ge    = rem2 >= trial;
         st_in[s]      = src;
         st_in[s].rem  = ge ? rem2 - trial : rem2;
         st_in[s].root = {src.root[ROOT_W-2:0], ge};
         st_in[s].v    = src.v << 2;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= src_vld;
         end
         if (rdy[s]) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign dn_valid     = vld_ff[ROOT_W-1];
   assign dn_data.ctl  = st_ff[ROOT_W-1].ctl;
   assign dn_data.mag  = st_ff[ROOT_W-1].mag;
   assign dn_data.half = st_ff[ROOT_W-1].root;

endmodule

// ----- src/qfrm_div.sv -----
// Division pipeline: three lanes of rounded restoring division by four times the root.
module qfrm_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  qfrm_pkg::root_type up_data,
   output logic               dn_valid,
   input  logic               dn_ready,
   output qfrm_pkg::quot_type dn_data
);
   import qfrm_pkg::*;

   typedef struct packed {
      ctl_type                     ctl;
      logic [ROOT_W-1:0]           half;
      logic [LANES-1:0]            ovf;
      logic [LANES-1:0][DEN_W-1:0] rem;
      logic [LANES-1:0][QB-1:0]    lo;
      logic [LANES-1:0][QB-1:0]    q;
   } dv_stage_type;

   localparam int NS = QB + 1;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   rdy;
   dv_stage_type  st_ff [NS];
   dv_stage_type  prep;

   // Form the rounded numerator, test for overflow, seed the remainder
   always_comb begin
      logic [NUM_W-1:0] num, hi;
      logic [DEN_W-1:0] den;
      prep.ctl  = up_data.ctl;
      prep.half = up_data.half;
      den = {up_data.half, 2'b00};
      for (int n = 0; n < LANES; n++) begin
         num = (NUM_W'(up_data.mag[n]) << FRAC_BITS) + NUM_W'({up_data.half, 1'b0});
         hi  = num >> QB;
         prep.ovf[n] = hi >= NUM_W'(den);
         prep.rem[n] = DEN_W'(hi);
         prep.lo[n]  = num[QB-1:0];
         prep.q[n]   = '0;
      end
   end

   assign rdy[NS]  = dn_ready;
   assign up_ready = rdy[0];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      dv_stage_type nxt;
      logic         src_vld;

      if (s == 0) begin : g_first
         assign nxt     = prep;
         assign src_vld = up_valid;
      end else begin : g_next
         dv_stage_type src;
         assign src     = st_ff[s-1];
         assign src_vld = vld_ff[s-1];
         // One quotient bit per lane
         always_comb begin
            logic [DEN_W:0]   rem2;
            logic [DEN_W-1:0] den;
            logic             ge;
            den = {src.half, 2'b00};
            nxt = src;
            for (int n = 0; n < LANES; n++) begin
               rem2 = {src.rem[n], src.lo[n][QB-1]};
               ge   = rem2 >= {1'b0, den};
               nxt.rem[n] = ge ? DEN_W'(rem2 - {1'b0, den}) : DEN_W'(rem2);
               nxt.q[n]   = {src.q[n][QB-2:0], ge};
               nxt.lo[n]  = src.lo[n] << 1;
            end
         end
      end

      assign rdy[s] = !vld_ff[s] || rdy[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= src_vld;
         end
         if (rdy[s]) begin
            st_ff[s] <= nxt;
         end
      end
   end

   assign dn_valid     = vld_ff[NS-1];
   assign dn_data.ctl  = st_ff[NS-1].ctl;
   assign dn_data.half = st_ff[NS-1].half;
   assign dn_data.ovf  = st_ff[NS-1].ovf;
   assign dn_data.q    = st_ff[NS-1].q;

endmodule

// ----- src/quaternion_from_rotation_matrix_core.sv -----
// Top level: rotation matrix to unit quaternion, fully pipelined.
// Takes one 3x3 rotation matrix (Q1.16 elements) per cycle and returns the unit quaternion
// (w,x,y,z) in Q1.16, saturated, with bad_matrix set and all components zero when the root
// argument is not positive. Throughput is one item per clock unless the result side stalls.
// The stages are one front stage, one stage per root bit in the square root, one
// numerator stage and one stage per quotient bit in the three division lanes, and the
// output register. Each stage moves on whenever the stage after it is empty or moving,
// so bubbles close up under a stall and items are taken while a result waits at the output.
module quaternion_from_rotation_matrix_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [qfrm_pkg::IN_W-1:0] req_r00,
   input  logic signed [qfrm_pkg::IN_W-1:0] req_r01,
   input  logic signed [qfrm_pkg::IN_W-1:0] req_r02,
   input  logic signed [qfrm_pkg::IN_W-1:0] req_r10,
   input  logic signed [qfrm_pkg::IN_W-1:0] req_r11,
   input  logic signed [qfrm_pkg::IN_W-1:0] req_r12,
   input  logic signed [qfrm_pkg::IN_W-1:0] req_r20,
   input  logic signed [qfrm_pkg::IN_W-1:0] req_r21,
   input  logic signed [qfrm_pkg::IN_W-1:0] req_r22,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [qfrm_pkg::OUT_W-1:0] rsp_qw,
   output logic signed [qfrm_pkg::OUT_W-1:0] rsp_qx,
   output logic signed [qfrm_pkg::OUT_W-1:0] rsp_qy,
   output logic signed [qfrm_pkg::OUT_W-1:0] rsp_qz,
   output logic                             rsp_bad_matrix
);
   import qfrm_pkg::*;

   logic      fr_valid, fr_ready, sq_valid, sq_ready, dv_valid, dv_ready, up_ready;
   front_type fr_data;
   root_type  sq_data;
   quot_type  dv_data;

   logic                    rsp_valid_ff, out_ready;
   logic signed [OUT_W-1:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [OUT_W-1:0] qw_in, qx_in, qy_in, qz_in;
   logic                    bad_ff;
   logic signed [OUT_W-1:0] hv;
   logic signed [OUT_W-1:0] lv [LANES];

   qfrm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (up_ready),
      .r00      (req_r00),
      .r01      (req_r01),
      .r02      (req_r02),
      .r10      (req_r10),
      .r11      (req_r11),
      .r12      (req_r12),
      .r20      (req_r20),
      .r21      (req_r21),
      .r22      (req_r22),
      .dn_valid (fr_valid),
      .dn_ready (fr_ready),
      .dn_data  (fr_data)
   );

   qfrm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .up_valid (fr_valid),
      .up_ready (fr_ready),
      .up_data  (fr_data),
      .dn_valid (sq_valid),
      .dn_ready (sq_ready),
      .dn_data  (sq_data)
   );

   qfrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .up_valid (sq_valid),
      .up_ready (sq_ready),
      .up_data  (sq_data),
      .dn_valid (dv_valid),
      .dn_ready (dv_ready),
      .dn_data  (dv_data)
   );

   assign req_stall = !up_ready;
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign dv_ready  = out_ready;

   // Saturate and route the root and the quotients to their slots
   always_comb begin
      hv = sat_half(dv_data.half);
      for (int n = 0; n < LANES; n++) begin
         lv[n] = sat_lane(dv_data.ctl.neg[n], dv_data.ovf[n], dv_data.q[n]);
      end
      case (dv_data.ctl.sel)
         SLOT_W: begin
            qw_in = hv;    qx_in = lv[0]; qy_in = lv[1]; qz_in = lv[2];
         end
         SLOT_X: begin
            qw_in = lv[0]; qx_in = hv;    qy_in = lv[1]; qz_in = lv[2];
         end
         SLOT_Y: begin
            qw_in = lv[0]; qx_in = lv[2]; qy_in = hv;    qz_in = lv[1];
         end
         SLOT_Z: begin
            qw_in = lv[0]; qx_in = lv[1]; qy_in = lv[2]; qz_in = hv;
         end
         default: begin
            qw_in = '0;    qx_in = '0;    qy_in = '0;    qz_in = '0;
         end
      endcase
      // Drop everything for a malformed matrix
      if (dv_data.ctl.bad) begin
         qw_in = '0;
         qx_in = '0;
         qy_in = '0;
         qz_in = '0;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= dv_valid;
      end
      if (out_ready) begin
         qw_ff  <= qw_in;
         qx_ff  <= qx_in;
         qy_ff  <= qy_in;
         qz_ff  <= qz_in;
         bad_ff <= dv_data.ctl.bad;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_qw         = qw_ff;
   assign rsp_qx         = qx_ff;
   assign rsp_qy         = qy_ff;
   assign rsp_qz         = qz_ff;
   assign rsp_bad_matrix = bad_ff;

   // A malformed matrix leaves all components zero
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_matrix |-> rsp_qw == 0 && rsp_qx == 0 && rsp_qy == 0 && rsp_qz == 0)
      else $error("bad matrix result carries non-zero components");

   // The input side stalls only when the whole pipeline is full behind a stalled result
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && fr_valid && sq_valid && dv_valid)
      else $error("input stalled with room in the pipeline");

   // Nothing is presented straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

// ----- verif/quaternion_from_rotation_matrix_checker.sv -----
// Checker for the rotation matrix to quaternion core: predicts each quaternion and compares it.
module quaternion_from_rotation_matrix_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic signed [qfrm_pkg::IN_W-1:0]   req_r00,
   input  logic signed [qfrm_pkg::IN_W-1:0]   req_r01,
   input  logic signed [qfrm_pkg::IN_W-1:0]   req_r02,
   input  logic signed [qfrm_pkg::IN_W-1:0]   req_r10,
   input  logic signed [qfrm_pkg::IN_W-1:0]   req_r11,
   input  logic signed [qfrm_pkg::IN_W-1:0]   req_r12,
   input  logic signed [qfrm_pkg::IN_W-1:0]   req_r20,
   input  logic signed [qfrm_pkg::IN_W-1:0]   req_r21,
   input  logic signed [qfrm_pkg::IN_W-1:0]   req_r22,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [qfrm_pkg::OUT_W-1:0]  rsp_qw,
   input  logic signed [qfrm_pkg::OUT_W-1:0]  rsp_qx,
   input  logic signed [qfrm_pkg::OUT_W-1:0]  rsp_qy,
   input  logic signed [qfrm_pkg::OUT_W-1:0]  rsp_qz,
   input  logic                               rsp_bad_matrix,
   output int                                 pending,
   output int                                 fail_count
);
   import qfrm_pkg::*;

   typedef struct packed {
      logic signed [OUT_W-1:0] qw;
      logic signed [OUT_W-1:0] qx;
      logic signed [OUT_W-1:0] qy;
      logic signed [OUT_W-1:0] qz;
      logic                    bad;
   } quat_type;

   quat_type quat_queue[$];

   // Integer square root, floored
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // s * 2^FRAC_BITS / (4*half), rounded half away from zero
   function automatic longint div_by_root(input longint s, input longint unsigned half);
      longint unsigned den;
      longint unsigned mag;
      longint unsigned q;
      den = half * 4;
      if (den == 0) return 0;
      mag = (s < 0) ? longint'(-s) : s;
      mag = mag << FRAC_BITS;
      q = (mag + den / 2) / den;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      return (s < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp(input longint v);
      if (v > OUT_MAX) return OUT_MAX;
      if (v < OUT_MIN) return OUT_MIN;
      return v[OUT_W-1:0];
   endfunction

   function automatic quat_type matrix_to_quat(input longint m[3][3]);
      longint q[4];
      longint one;
      longint trace;
      longint arg;
      longint unsigned half;
      int i, j, k;
      quat_type res;
      one = longint'(1) << FRAC_BITS;
      q = '{0, 0, 0, 0};
      res.bad = 1'b0;
      trace = m[0][0] + m[1][1] + m[2][2];
      if (trace > 0) begin
         arg = trace + one;
         half = int_sqrt(longint'(arg) << (FRAC_BITS - 2));
         q[0] = half;
         q[1] = div_by_root(m[2][1] - m[1][2], half);
         q[2] = div_by_root(m[0][2] - m[2][0], half);
         q[3] = div_by_root(m[1][0] - m[0][1], half);
      end else begin
         // Largest diagonal wins; ties keep the earlier axis
         i = 0;
         if (m[1][1] > m[0][0]) i = 1;
         if (m[2][2] > m[i][i]) i = 2;
         j = (i + 1) % 3;
         k = (j + 1) % 3;
         arg = m[i][i] - m[j][j] - m[k][k] + one;
         if (arg <= 0) begin
            res.bad = 1'b1;
         end else begin
            half = int_sqrt(longint'(arg) << (FRAC_BITS - 2));
            q[1 + i] = half;
            q[0] = div_by_root(m[k][j] - m[j][k], half);
            q[1 + j] = div_by_root(m[j][i] + m[i][j], half);
            q[1 + k] = div_by_root(m[k][i] + m[i][k], half);
         end
      end
      res.qw = clamp(q[0]);
      res.qx = clamp(q[1]);
      res.qy = clamp(q[2]);
      res.qz = clamp(q[3]);
      return res;
   endfunction

   // Predict on each accepted matrix, compare each accepted quaternion
   always @(posedge clock) begin
      longint m[3][3];
      quat_type exp_q;
      quat_type got_q;
      if (reset) begin
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            m[0][0] = req_r00; m[0][1] = req_r01; m[0][2] = req_r02;
            m[1][0] = req_r10; m[1][1] = req_r11; m[1][2] = req_r12;
            m[2][0] = req_r20; m[2][1] = req_r21; m[2][2] = req_r22;
            quat_queue.push_back(matrix_to_quat(m));
         end
         if (rsp_valid && !rsp_stall) begin
            got_q = '{rsp_qw, rsp_qx, rsp_qy, rsp_qz, rsp_bad_matrix};
            if (quat_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected item: %p", got_q);
               fail_count <= fail_count + 1;
            end else begin
               exp_q = quat_queue.pop_front();
               if (got_q !== exp_q) begin
                  if (fail_count < 10) $display("mismatch: expected %p got %p", exp_q, got_q);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= quat_queue.size();
      end
   end

endmodule

// ----- verif/quaternion_from_rotation_matrix_core_tb.sv -----
// Testbench top: drives matrices into the core and reports the verdict.
module quaternion_from_rotation_matrix_core_tb;
   import qfrm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [IN_W-1:0] req_r00 = '0, req_r01 = '0, req_r02 = '0;
   logic signed [IN_W-1:0] req_r10 = '0, req_r11 = '0, req_r12 = '0;
   logic signed [IN_W-1:0] req_r20 = '0, req_r21 = '0, req_r22 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_qw, rsp_qx, rsp_qy, rsp_qz;
   logic rsp_bad_matrix;
   int pending;
   int fail_count;
   bit quiet = 1'b0;

   localparam int ONE = 1 << FRAC_BITS;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quaternion_from_rotation_matrix_core dut (.*);

   quaternion_from_rotation_matrix_checker checker_i (.*);

   // Stall the result side at random, except in the quiet stretch
   always @(posedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 38);
   end

   // Offer one matrix, idling at random first, and hold it until taken
   task automatic send_matrix(input int e[9]);
      while (!quiet && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_r00 <= IN_W'(e[0]); req_r01 <= IN_W'(e[1]); req_r02 <= IN_W'(e[2]);
      req_r10 <= IN_W'(e[3]); req_r11 <= IN_W'(e[4]); req_r12 <= IN_W'(e[5]);
      req_r20 <= IN_W'(e[6]); req_r21 <= IN_W'(e[7]); req_r22 <= IN_W'(e[8]);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Proper rotation from a random unnormalised quaternion
   task automatic rotation_matrix(output int e[9]);
      longint w, x, y, z, n;
      do begin
         w = $signed($urandom_range(512)) - 256;
         x = $signed($urandom_range(512)) - 256;
         y = $signed($urandom_range(512)) - 256;
         z = $signed($urandom_range(512)) - 256;
         n = w*w + x*x + y*y + z*z;
      end while (n == 0);
      e[0] = int'((w*w + x*x - y*y - z*z) * ONE / n);
      e[1] = int'(2 * (x*y - w*z) * ONE / n);
      e[2] = int'(2 * (x*z + w*y) * ONE / n);
      e[3] = int'(2 * (x*y + w*z) * ONE / n);
      e[4] = int'((w*w - x*x + y*y - z*z) * ONE / n);
      e[5] = int'(2 * (y*z - w*x) * ONE / n);
      e[6] = int'(2 * (x*z - w*y) * ONE / n);
      e[7] = int'(2 * (y*z + w*x) * ONE / n);
      e[8] = int'((w*w - x*x - y*y + z*z) * ONE / n);
   endtask

   initial begin
      int e[9];
      int sel;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity, half turns, ties, extremes, zero and malformed diagonals
      send_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
      send_matrix('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE});
      send_matrix('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE});
      send_matrix('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE});
      send_matrix('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE});
      send_matrix('{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE});
      send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_matrix('{131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071});
      send_matrix('{-131072, -131072, -131072, -131072, -131072, -131072, -131072, -131072,
                    -131072});
      send_matrix('{-131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071,
                    -131072});
      send_matrix('{131071, -131072, 131071, -131072, -131072, -131072, 131071, -131072,
                    -131072});
      send_matrix('{-131072, -131072, 131071, 131071, 131071, -131072, -131072, 131071,
                    -131072});
      send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 1});
      send_matrix('{1, 131071, -131072, -131072, 0, 131071, 131071, -131072, -1});
      send_matrix('{-ONE, 5, 7, 3, -ONE, 9, 2, 4, -ONE + 1});
      send_matrix('{-100, 20000, -20000, 20000, -100, 3, 4, 5, -100});

      // Random: proper rotations, perturbed rotations and raw noise
      for (int n = 0; n < 1000; n++) begin
         quiet = (n >= 400 && n < 600);
         sel = $urandom_range(99);
         if (sel < 45) begin
            rotation_matrix(e);
         end else if (sel < 70) begin
            rotation_matrix(e);
            foreach (e[i]) e[i] = e[i] + $signed($urandom_range(2048)) - 1024;
         end else begin
            foreach (e[i]) e[i] = $signed($urandom_range(262143)) - 131072;
         end
         send_matrix(e);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // Drain, then let the pipeline settle
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule
